### sv/drp_pkg.sv
package drp_pkg;

    // Fixed formats of the datapath
    localparam int CFG_W    = 32;            // every register is 32 bits
    localparam int CFG_IDX_W = 3;            // register index width
    localparam int DISP_W   = 16;            // Q12.4 disparity
    localparam int RGB_W    = 24;            // red, green, blue
    localparam int COORD_W  = 32;            // Q16.16 result coordinate
    localparam int LANES    = 3;             // X, Y, Z
    localparam int QBITS    = 33;            // quotient bits kept (one past the sign bit)
    localparam int WMAG_W   = 48;            // |w| < 2^47, Q.28
    localparam int NUM_W    = 34;            // numerator, Q.16, |n| < 2^33
    localparam int PRE_SH   = QBITS - 28;    // alignment of n*2^28 against w*2^QBITS
    localparam int M_TDATA_W = LANES * COORD_W + RGB_W;

    localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [QBITS-1:0]   NEG_LIM = QBITS'(SAT_MIN);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_X         = 3'd0,
        CFG_OFFSET_Y         = 3'd1,
        CFG_FOCAL            = 3'd2,
        CFG_INV_BASELINE     = 3'd3,
        CFG_PRINCIPAL_OFFSET = 3'd4
    } cfg_idx_t;

    typedef logic [WMAG_W-1:0] wmag_t;

    // One divider lane: partial remainder and dividend bits still to bring down
    typedef struct packed {
        logic [WMAG_W-1:0] rem;
        logic [QBITS-1:0]  dlo;
    } drp_lane_t;

    // Per-item flags that ride alongside the divider
    typedef struct packed {
        logic             wzero;
        logic [LANES-1:0] nneg;
        logic [LANES-1:0] nzero;
        logic [LANES-1:0] qneg;
        logic [LANES-1:0] big;
        logic [RGB_W-1:0] rgb;
    } drp_side_t;

endpackage

### sv/drp_div.sv
// Restoring divider, one quotient bit per stage, three lanes sharing one divisor.
module drp_div (
    input  logic                                             aclk,
    input  logic [drp_pkg::QBITS-1:0]                        en,
    input  drp_pkg::wmag_t                                   wmag_in,
    input  drp_pkg::drp_lane_t [drp_pkg::LANES-1:0]          lane_in,
    output logic [drp_pkg::LANES-1:0][drp_pkg::QBITS-1:0]    q_out
);

    localparam int QB = drp_pkg::QBITS;
    localparam int NL = drp_pkg::LANES;
    localparam int WW = drp_pkg::WMAG_W;

    drp_pkg::wmag_t                    wmag_reg [QB];
    drp_pkg::drp_lane_t [NL-1:0]       lane_reg [QB];
    logic [NL-1:0][QB-1:0]             q_reg    [QB];

    drp_pkg::drp_lane_t [NL-1:0]       lane_next [QB];
    logic [NL-1:0][QB-1:0]             q_next    [QB];

    genvar k, l;
    for (k = 0; k < QB; k++) begin : g_stage
        drp_pkg::wmag_t              wm_cur;
        drp_pkg::drp_lane_t [NL-1:0] ln_cur;
        logic [NL-1:0][QB-1:0]       q_cur;

        if (k == 0) begin : g_first
            assign wm_cur = wmag_in;
            assign ln_cur = lane_in;
            assign q_cur  = '0;
        end else begin : g_rest
            assign wm_cur = wmag_reg[k-1];
            assign ln_cur = lane_reg[k-1];
            assign q_cur  = q_reg[k-1];
        end

        for (l = 0; l < NL; l++) begin : g_lane
            logic [WW:0] rsh;
            logic [WW:0] diff;
            logic        take;

            // bring down next dividend bit, then trial subtract
            assign rsh  = {ln_cur[l].rem, ln_cur[l].dlo[QB-1]};
            assign diff = rsh - {1'b0, wm_cur};
            assign take = (rsh >= {1'b0, wm_cur});

            assign lane_next[k][l].rem = take ? diff[WW-1:0] : rsh[WW-1:0];
            assign lane_next[k][l].dlo = {ln_cur[l].dlo[QB-2:0], 1'b0};
            assign q_next[k][l]        = {q_cur[l][QB-2:0], take};
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                wmag_reg[k] <= wm_cur;
                lane_reg[k] <= lane_next[k];
                q_reg[k]    <= q_next[k];
            end
        end
    end

    assign q_out = q_reg[QB-1];

endmodule

### sv/disparity_reproject_q_matrix.sv
// Stereo reprojection: one rectified pixel in, one colored 3-D point out.
// Input channel s_*: col, row, disparity (Q12.4) and color packed in s_tdata.
// A pixel with disparity zero or negative is taken and dropped with no result.
// Output channel m_*: X, Y, Z (Q16.16, saturated) and the color in m_tdata,
// m_tuser[0] flags saturation or a zero w.
// The user loads registers via cfg_wr_en / cfg_addr / cfg_wdata only while
// idle; the block does not enforce it. An index beyond the list is ignored.
// Throughput: one item per clock while the receiver holds m_tready high. The
// item passes 39 register stages, the first loaded at the accepting edge:
// five front stages (capture, 32x16 multiply, w add, magnitudes, range
// check), 33 divider stages at one quotient bit each, and the output
// register.
// Each stage holds a valid bit; a stage loads when it is empty or the one
// after it moves, so bubbles close up. When the receiver stalls, items pile
// up behind the output register and s_tready drops once every stage is full;
// nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and the configuration registers.
module disparity_reproject_q_matrix #(
    parameter int COORD_BITS = 12
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration
    input  logic                                  cfg_wr_en,
    input  logic [drp_pkg::CFG_IDX_W-1:0]         cfg_addr,
    input  logic [drp_pkg::CFG_W-1:0]             cfg_wdata,
    // input pixels
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // col, row, disparity, red, green, blue, zero pad
    input  logic [((2 * COORD_BITS + drp_pkg::DISP_W + drp_pkg::RGB_W + 7) / 8) * 8 - 1:0]
                                                  s_tdata,
    // output points
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // point_x, point_y, point_z, out_red, out_green, out_blue
    output logic [drp_pkg::M_TDATA_W-1:0]         m_tdata,
    // overflow
    output logic [0:0]                            m_tuser
);

    localparam int QB   = drp_pkg::QBITS;
    localparam int NL   = drp_pkg::LANES;
    localparam int WW   = drp_pkg::WMAG_W;
    localparam int NW   = drp_pkg::NUM_W;
    localparam int CW   = drp_pkg::COORD_W;
    localparam int PRE  = 5;
    localparam int OUT  = PRE + QB;
    localparam int NSTG = OUT + 1;

    // ---------------------------------------------------------------
    // Configuration registers
    logic [drp_pkg::CFG_W-1:0] ox_reg, oy_reg, focal_reg, ib_reg, po_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ox_reg    <= '0;
            oy_reg    <= '0;
            focal_reg <= '0;
            ib_reg    <= '0;
            po_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                drp_pkg::CFG_OFFSET_X:         ox_reg    <= cfg_wdata;
                drp_pkg::CFG_OFFSET_Y:         oy_reg    <= cfg_wdata;
                drp_pkg::CFG_FOCAL:            focal_reg <= cfg_wdata;
                drp_pkg::CFG_INV_BASELINE:     ib_reg    <= cfg_wdata;
                drp_pkg::CFG_PRINCIPAL_OFFSET: po_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage valids and load enables
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] en_w;

    assign en_w[NSTG-1] = !v_reg[NSTG-1] || m_tready;
    genvar gi;
    for (gi = 0; gi < NSTG - 1; gi++) begin : g_en
        assign en_w[gi] = !v_reg[gi] || en_w[gi+1];
    end

    assign s_tready = en_w[0];

    // input fields
    logic [COORD_BITS-1:0]       s_col, s_row;
    logic [drp_pkg::DISP_W-1:0]  s_disp;
    logic [drp_pkg::RGB_W-1:0]   s_rgb;
    logic                        in_ok;

    assign s_col  = s_tdata[COORD_BITS-1:0];
    assign s_row  = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign s_disp = s_tdata[2*COORD_BITS +: drp_pkg::DISP_W];
    assign s_rgb  = s_tdata[2*COORD_BITS + drp_pkg::DISP_W +: drp_pkg::RGB_W];
    assign in_ok  = s_tvalid && ($signed(s_disp) > $signed(16'sd0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en_w[0]) begin
                v_reg[0] <= in_ok;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (en_w[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: capture
    logic [COORD_BITS-1:0]      col0_reg, row0_reg;
    logic [drp_pkg::DISP_W-1:0] disp0_reg;
    logic [drp_pkg::RGB_W-1:0]  rgb0_reg;

    always_ff @(posedge aclk) begin
        if (en_w[0]) begin
            col0_reg  <= s_col;
            row0_reg  <= s_row;
            disp0_reg <= s_disp;
            rgb0_reg  <= s_rgb;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: w product and numerators
    logic signed [WW-1:0]      ib_ext, d_ext, prod1_next, prod1_reg;
    logic signed [NW-1:0]      ox_ext, oy_ext, col_ext, row_ext;
    logic signed [NW-1:0]      n1_next [NL];
    logic signed [NW-1:0]      n1_reg  [NL];
    logic [drp_pkg::RGB_W-1:0] rgb1_reg;

    assign ib_ext     = WW'($signed(ib_reg));
    assign d_ext      = WW'($signed(disp0_reg));
    assign prod1_next = ib_ext * d_ext;
    assign ox_ext     = NW'($signed(ox_reg));
    assign oy_ext     = NW'($signed(oy_reg));
    assign col_ext    = $signed(NW'({col0_reg, 16'b0}));
    assign row_ext    = $signed(NW'({row0_reg, 16'b0}));
    assign n1_next[0] = -(ox_ext + col_ext);
    assign n1_next[1] = -(oy_ext + row_ext);
    assign n1_next[2] = NW'($signed(focal_reg));

    always_ff @(posedge aclk) begin
        if (en_w[1]) begin
            prod1_reg <= prod1_next;
            n1_reg    <= n1_next;
            rgb1_reg  <= rgb0_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: w = ib*d + 16*po, numerator magnitudes
    logic signed [WW-1:0]      po_ext, w2_reg;
    logic [NW-1:0]             nmag2_reg [NL];
    logic [NL-1:0]             nneg2_reg, nzero2_reg;
    logic [drp_pkg::RGB_W-1:0] rgb2_reg;

    assign po_ext = $signed({{(WW - drp_pkg::CFG_W - 4){po_reg[drp_pkg::CFG_W-1]}},
                             po_reg, 4'b0});

    always_ff @(posedge aclk) begin
        if (en_w[2]) begin
            w2_reg <= prod1_reg + po_ext;
            for (int l = 0; l < NL; l++) begin
                nmag2_reg[l]  <= n1_reg[l][NW-1] ? NW'(-n1_reg[l]) : NW'(n1_reg[l]);
                nneg2_reg[l]  <= n1_reg[l][NW-1];
                nzero2_reg[l] <= (n1_reg[l] == '0);
            end
            rgb2_reg <= rgb1_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: |w|
    drp_pkg::wmag_t            wmag3_reg;
    logic                      wneg3_reg, wzero3_reg;
    logic [NW-1:0]             nmag3_reg [NL];
    logic [NL-1:0]             nneg3_reg, nzero3_reg;
    logic [drp_pkg::RGB_W-1:0] rgb3_reg;

    always_ff @(posedge aclk) begin
        if (en_w[3]) begin
            wmag3_reg  <= w2_reg[WW-1] ? WW'(-w2_reg) : WW'(w2_reg);
            wneg3_reg  <= w2_reg[WW-1];
            wzero3_reg <= (w2_reg == '0);
            nmag3_reg  <= nmag2_reg;
            nneg3_reg  <= nneg2_reg;
            nzero3_reg <= nzero2_reg;
            rgb3_reg   <= rgb2_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: range check and divider setup
    // quotient of n*2^28/w reaches 2^QBITS exactly when |n| >= |w|*2^PRE_SH
    localparam int CMP_W = WW + drp_pkg::PRE_SH;

    drp_pkg::wmag_t                        wmag4_reg;
    drp_pkg::drp_lane_t [NL-1:0]           lane4_reg;
    drp_pkg::drp_side_t                    side_reg [QB+1];
    drp_pkg::drp_side_t                    side4_next;
    drp_pkg::drp_lane_t [NL-1:0]           lane4_next;

    always_comb begin
        side4_next.wzero = wzero3_reg;
        side4_next.nneg  = nneg3_reg;
        side4_next.nzero = nzero3_reg;
        side4_next.rgb   = rgb3_reg;
        for (int l = 0; l < NL; l++) begin
            side4_next.qneg[l] = nneg3_reg[l] ^ wneg3_reg;
            side4_next.big[l]  = (CMP_W'(nmag3_reg[l])
                                  >= {wmag3_reg, {drp_pkg::PRE_SH{1'b0}}});
            lane4_next[l].rem  = WW'(nmag3_reg[l][NW-1:drp_pkg::PRE_SH]);
            lane4_next[l].dlo  = {nmag3_reg[l][drp_pkg::PRE_SH-1:0],
                                  {(QB - drp_pkg::PRE_SH){1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (en_w[4]) begin
            wmag4_reg   <= wmag3_reg;
            lane4_reg   <= lane4_next;
        end
    end

    // ---------------------------------------------------------------
    // Divider stages, flags ride along
    logic [NL-1:0][QB-1:0] q_w;

    drp_div u_div (
        .aclk    (aclk),
        .en      (en_w[PRE +: QB]),
        .wmag_in (wmag4_reg),
        .lane_in (lane4_reg),
        .q_out   (q_w)
    );

    always_ff @(posedge aclk) begin
        if (en_w[PRE - 1]) begin
            side_reg[0] <= side4_next;
        end
        for (int j = 1; j <= QB; j++) begin
            if (en_w[PRE - 1 + j]) begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Output stage: sign, saturation
    drp_pkg::drp_side_t side_o;
    logic [CW-1:0]      coord_next [NL];
    logic [NL-1:0]      ovf_l;
    logic [QB-1:0]      q_neg;

    assign side_o = side_reg[QB];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            q_neg = -q_w[l];
            priority if (side_o.wzero) begin
                ovf_l[l] = 1'b1;
                if (side_o.nzero[l]) begin
                    coord_next[l] = '0;
                end else begin
                    coord_next[l] = side_o.nneg[l] ? drp_pkg::SAT_MIN : drp_pkg::SAT_MAX;
                end
            end else if (side_o.big[l]) begin
                ovf_l[l]      = 1'b1;
                coord_next[l] = side_o.qneg[l] ? drp_pkg::SAT_MIN : drp_pkg::SAT_MAX;
            end else if (side_o.qneg[l]) begin
                ovf_l[l]      = (q_w[l] > drp_pkg::NEG_LIM);
                coord_next[l] = ovf_l[l] ? drp_pkg::SAT_MIN : q_neg[CW-1:0];
            end else begin
                ovf_l[l]      = q_w[l][QB-1] | q_w[l][CW-1];
                coord_next[l] = ovf_l[l] ? drp_pkg::SAT_MAX : q_w[l][CW-1:0];
            end
        end
    end

    logic [CW-1:0]             px_reg, py_reg, pz_reg;
    logic [drp_pkg::RGB_W-1:0] rgbo_reg;
    logic                      ovf_reg;

    always_ff @(posedge aclk) begin
        if (en_w[OUT]) begin
            px_reg   <= coord_next[0];
            py_reg   <= coord_next[1];
            pz_reg   <= coord_next[2];
            rgbo_reg <= side_o.rgb;
            ovf_reg  <= |ovf_l;
        end
    end

    assign m_tvalid   = v_reg[OUT];
    assign m_tdata    = {rgbo_reg, pz_reg, py_reg, px_reg};
    assign m_tuser[0] = ovf_reg;

`ifndef SYNTHESIS
    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output stage");

    // a ready receiver lets the whole pipeline move
    a_ready_through: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("pipeline stalled with receiver ready");

    // pixels without a positive disparity never enter the pipeline
    a_drop_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !($signed(s_disp) > $signed(16'sd0))) |=> !v_reg[0])
        else $error("invalid disparity produced a valid item");

    // a held divider stage keeps its item
    a_div_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[PRE] && !en_w[PRE]) |=> v_reg[PRE])
        else $error("divider stage lost an item while stalled");

    // a zero w always raises the overflow flag
    a_wzero_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[OUT-1] && en_w[OUT] && side_o.wzero) |=> m_tuser[0])
        else $error("zero w without overflow flag");
`endif

endmodule
